// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define BIA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent in the next.
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

	// map word geometry
	localparam int unsigned WORD_W = 64;
	localparam int unsigned OFF_W  = 6;

	// fixed field widths
	localparam int unsigned ID_W   = 32;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned SKIP_W = 4;
	localparam int unsigned SKIP_N = 16;

	// operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_ID_BASE    = 3'd0;
	localparam logic [2:0] REG_ID_COUNT   = 3'd1;
	localparam logic [2:0] REG_RESERVED   = 3'd2;
	localparam logic [2:0] REG_RANDOM     = 3'd3;
	localparam logic [2:0] REG_KEEP_EMPTY = 3'd4;

	localparam logic [ID_W-1:0] ALLOC_FAIL_ID = '1;

	typedef logic [WORD_W-1:0] word_t;

	// n low bits set; n of 64 or more gives all ones
	function automatic word_t lomask(input logic [OFF_W:0] n);
		word_t m;
		if (n >= 7'(WORD_W)) begin
			m = '1;
		end else begin
			m = (word_t'(1) << n) - word_t'(1);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_id_allocator.sv =====
`default_nettype none

// Channel    Ports                                   Transfer
// command    start, operation, id_in, skip_in        start & !busy
// result     done, id_out, status                    done, one cycle
// config     cfg_wr_en, cfg_index, cfg_wdata         cfg_wr_en, any cycle
//
// The used map sits in a memory of 64-bit words, NWORDS = ceil(MAP_SIZE/64).
// Allocate reads one word per cycle through a single search unit, at most NWORDS + 1
// words (17 at the default size); a found ID adds a write of the word, a full map ends
// the scan, and when no IDs are managed the result comes without any read.
// Free runs compare, read, write; init sweeps every word; other codes answer from idle.
// After reset the map is swept to zero with busy high.
// done drops busy in the same cycle; the receiver cannot stall a result.

`include "assert_macros.svh"

module bitmap_id_allocator #(
	parameter int unsigned MAP_SIZE   = 1024,
	parameter int unsigned SKIP_RANGE = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    operation,
	input  wire logic [bia_pkg::ID_W-1:0]      id_in,
	input  wire logic [bia_pkg::SKIP_W-1:0]    skip_in,
	// result
	output logic                               done,
	output logic [bia_pkg::ID_W-1:0]           id_out,
	output logic [1:0]                         status,
	// config
	input  wire logic                          cfg_wr_en,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [bia_pkg::ID_W-1:0]      cfg_wdata
);

	localparam int unsigned OFF_W  = bia_pkg::OFF_W;
	localparam int unsigned WORD_W = bia_pkg::WORD_W;
	localparam int unsigned IW     = $clog2(MAP_SIZE);
	localparam int unsigned NWORDS = (MAP_SIZE + WORD_W - 1) / WORD_W;
	localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int unsigned FW     = AW + OFF_W;
	localparam int unsigned EW     = (bia_pkg::CNT_W > IW + 1) ? bia_pkg::CNT_W : IW + 1;
	localparam int unsigned RW     = ((EW > FW) ? EW : FW) + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CLEAR    = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_ALLOC_WR = 3'd3;
	localparam logic [2:0] S_FREE_CHK = 3'd4;
	localparam logic [2:0] S_FREE_RD  = 3'd5;
	localparam logic [2:0] S_FREE_WR  = 3'd6;

	// configuration registers
	logic [bia_pkg::ID_W-1:0]  id_base_q;
	logic [bia_pkg::CNT_W-1:0] id_count_q;
	logic [bia_pkg::CNT_W-1:0] reserved_count_q;
	logic                      random_mode_q;
	logic                      keep_empty_q;

	// control and item state
	logic [2:0]                 state_q;
	logic [1:0]                 op_q;
	logic [bia_pkg::ID_W-1:0]   id_in_q;
	logic [bia_pkg::SKIP_W-1:0] skip_q;
	logic [IW-1:0]              next_pos_q;
	logic [AW-1:0]              sweep_word_q;
	logic                       sweep_init_q;
	logic [AW-1:0]              sc_word_q;
	logic                       sc_pass_q;
	logic                       sc_issue_q;
	logic                       chk_vld_s1;
	logic [AW-1:0]              chk_word_s1;
	logic                       chk_pass_s1;
	bia_pkg::word_t             alloc_data_q;
	logic [AW-1:0]              alloc_word_q;
	logic [OFF_W-1:0]           alloc_off_q;
	logic [AW-1:0]              free_word_q;
	logic [OFF_W-1:0]           free_off_q;
	logic                       done_q;
	logic [bia_pkg::ID_W-1:0]   id_out_q;
	logic [1:0]                 status_q;

	// map memory
	bia_pkg::word_t mem [NWORDS];
	bia_pkg::word_t rdata_q;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_wa;
	logic [AW-1:0]  mem_ra;
	bia_pkg::word_t mem_wd;

	// derived values
	logic [bia_pkg::SKIP_W-1:0] skip_tbl [bia_pkg::SKIP_N];
	logic [bia_pkg::SKIP_W-1:0] skip_mod;
	logic [EW-1:0]              cnt;
	logic [EW-1:0]              cnt_m1;
	logic [EW-1:0]              res_eff;
	logic [AW-1:0]              last_word;
	logic [OFF_W:0]             end_off;
	logic [FW-1:0]              start_pos;
	logic [AW-1:0]              start_word;
	logic [OFF_W-1:0]           start_off;
	logic [RW-1:0]              sweep_base;
	logic [RW-1:0]              sweep_diff;
	bia_pkg::word_t             sweep_pattern;
	logic [OFF_W:0]             srch_lo;
	logic [OFF_W:0]             srch_hi;
	logic                       srch_found;
	logic [OFF_W-1:0]           srch_off;
	logic [bia_pkg::ID_W-1:0]   free_idx;
	logic [FW-1:0]              free_pos;
	logic [FW-1:0]              alloc_idx;
	logic [RW-1:0]              np_sum;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign id_out = id_out_q;
	assign status = status_q;

	// skip modulo range, worked out per code at elaboration
	for (genvar g = 0; g < bia_pkg::SKIP_N; g++) begin : g_skip
		localparam int unsigned SKIP_MOD = g % SKIP_RANGE;
		assign skip_tbl[g] = bia_pkg::SKIP_W'(SKIP_MOD);
	end
	assign skip_mod = skip_tbl[skip_in];

	// effective count and reserved span
	assign cnt     = (EW'(id_count_q) > EW'(MAP_SIZE)) ? EW'(MAP_SIZE) : EW'(id_count_q);
	assign cnt_m1  = cnt - EW'(1);
	assign res_eff = keep_empty_q ? '0 :
	                 ((EW'(reserved_count_q) > cnt) ? cnt : EW'(reserved_count_q));

	// search window limits
	assign last_word  = AW'(cnt_m1 >> OFF_W);
	assign end_off    = (OFF_W + 1)'(cnt_m1[OFF_W-1:0]) + (OFF_W + 1)'(1);
	assign start_pos  = (EW'(next_pos_q) < cnt) ? FW'(next_pos_q) : '0;
	assign start_word = start_pos[FW-1:OFF_W];
	assign start_off  = start_pos[OFF_W-1:0];

	// init fill pattern for the word being swept
	assign sweep_base = RW'({sweep_word_q, {OFF_W{1'b0}}});
	assign sweep_diff = RW'(res_eff) - sweep_base;
	assign sweep_pattern = (RW'(res_eff) > sweep_base) ?
		bia_pkg::lomask((sweep_diff >= RW'(WORD_W)) ? (OFF_W + 1)'(WORD_W) :
		                sweep_diff[OFF_W:0]) : '0;

	// window for the word now in the check stage
	always_comb begin
		srch_lo = '0;
		srch_hi = (OFF_W + 1)'(WORD_W);
		if (!chk_pass_s1) begin
			if (chk_word_s1 == start_word) srch_lo = {1'b0, start_off};
			if (chk_word_s1 == last_word)  srch_hi = end_off;
		end else begin
			if (chk_word_s1 == start_word) srch_hi = {1'b0, start_off};
			else if (chk_word_s1 == last_word) srch_hi = end_off;
		end
	end

	bia_word_search u_search (
		.data  (rdata_q),
		.lo    (srch_lo),
		.hi    (srch_hi),
		.found (srch_found),
		.off   (srch_off)
	);

	assign free_idx  = id_in_q - id_base_q;
	assign free_pos  = FW'(free_idx);
	assign alloc_idx = {alloc_word_q, alloc_off_q};
	assign np_sum    = random_mode_q ? (RW'(next_pos_q) + RW'(skip_q)) :
	                                   (RW'(alloc_idx) + RW'(1));

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_word_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = sc_word_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = sweep_init_q ? sweep_pattern : '0;
			end
			S_SCAN: begin
				mem_re = sc_issue_q;
			end
			S_ALLOC_WR: begin
				mem_we = 1'b1;
				mem_wa = alloc_word_q;
				mem_wd = alloc_data_q | (bia_pkg::word_t'(1) << alloc_off_q);
			end
			S_FREE_RD: begin
				mem_re = 1'b1;
				mem_ra = free_word_q;
			end
			S_FREE_WR: begin
				mem_we = 1'b1;
				mem_wa = free_word_q;
				mem_wd = rdata_q & ~(bia_pkg::word_t'(1) << free_off_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q        <= '0;
			id_count_q       <= bia_pkg::CNT_W'(1024);
			reserved_count_q <= '0;
			random_mode_q    <= 1'b0;
			keep_empty_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bia_pkg::REG_ID_BASE:    id_base_q        <= cfg_wdata;
				bia_pkg::REG_ID_COUNT:   id_count_q       <= cfg_wdata[bia_pkg::CNT_W-1:0];
				bia_pkg::REG_RESERVED:   reserved_count_q <= cfg_wdata[bia_pkg::CNT_W-1:0];
				bia_pkg::REG_RANDOM:     random_mode_q    <= cfg_wdata[0];
				bia_pkg::REG_KEEP_EMPTY: keep_empty_q     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			op_q         <= bia_pkg::OP_ALLOC;
			id_in_q      <= '0;
			skip_q       <= '0;
			next_pos_q   <= '0;
			sweep_word_q <= '0;
			sweep_init_q <= 1'b0;
			sc_word_q    <= '0;
			sc_pass_q    <= 1'b0;
			sc_issue_q   <= 1'b0;
			chk_vld_s1   <= 1'b0;
			chk_word_s1  <= '0;
			chk_pass_s1  <= 1'b0;
			alloc_data_q <= '0;
			alloc_word_q <= '0;
			alloc_off_q  <= '0;
			free_word_q  <= '0;
			free_off_q   <= '0;
			done_q       <= 1'b0;
			id_out_q     <= '0;
			status_q     <= bia_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						id_in_q <= id_in;
						skip_q  <= skip_mod;
						case (operation)
							bia_pkg::OP_ALLOC: begin
								if (cnt == '0) begin
									done_q   <= 1'b1;
									id_out_q <= bia_pkg::ALLOC_FAIL_ID;
									status_q <= bia_pkg::ST_FULL;
								end else begin
									state_q    <= S_SCAN;
									sc_word_q  <= start_word;
									sc_pass_q  <= 1'b0;
									sc_issue_q <= 1'b1;
									chk_vld_s1 <= 1'b0;
								end
							end
							bia_pkg::OP_FREE: begin
								state_q <= S_FREE_CHK;
							end
							bia_pkg::OP_INIT: begin
								state_q      <= S_CLEAR;
								sweep_word_q <= '0;
								sweep_init_q <= 1'b1;
								next_pos_q   <= random_mode_q ? IW'(skip_mod) : '0;
							end
							default: begin
								done_q   <= 1'b1;
								id_out_q <= '0;
								status_q <= bia_pkg::ST_OK;
							end
						endcase
					end
				end
				// one word per cycle, both for reset clearing and init
				S_CLEAR: begin
					if (sweep_word_q == LAST_WORD) begin
						state_q <= S_IDLE;
						if (sweep_init_q) begin
							done_q   <= 1'b1;
							id_out_q <= '0;
							status_q <= bia_pkg::ST_OK;
						end
					end else begin
						sweep_word_q <= sweep_word_q + AW'(1);
					end
				end
				// read stage issues words, check stage tests the one read before
				S_SCAN: begin
					chk_vld_s1  <= sc_issue_q;
					chk_word_s1 <= sc_word_q;
					chk_pass_s1 <= sc_pass_q;
					if (sc_issue_q) begin
						if (!sc_pass_q && sc_word_q == last_word) begin
							sc_pass_q <= 1'b1;
							sc_word_q <= '0;
						end else if (sc_pass_q && sc_word_q == start_word) begin
							sc_issue_q <= 1'b0;
						end else begin
							sc_word_q <= sc_word_q + AW'(1);
						end
					end
					if (chk_vld_s1) begin
						if (srch_found) begin
							state_q      <= S_ALLOC_WR;
							sc_issue_q   <= 1'b0;
							alloc_data_q <= rdata_q;
							alloc_word_q <= chk_word_s1;
							alloc_off_q  <= srch_off;
						end else if (chk_pass_s1 && chk_word_s1 == start_word) begin
							state_q    <= S_IDLE;
							sc_issue_q <= 1'b0;
							done_q     <= 1'b1;
							id_out_q   <= bia_pkg::ALLOC_FAIL_ID;
							status_q   <= bia_pkg::ST_FULL;
						end
					end
				end
				S_ALLOC_WR: begin
					state_q    <= S_IDLE;
					done_q     <= 1'b1;
					id_out_q   <= id_base_q + bia_pkg::ID_W'(alloc_idx);
					status_q   <= bia_pkg::ST_OK;
					next_pos_q <= (np_sum >= RW'(cnt)) ? '0 : IW'(np_sum);
				end
				S_FREE_CHK: begin
					if (free_idx < bia_pkg::ID_W'(cnt)) begin
						state_q     <= S_FREE_RD;
						free_word_q <= free_pos[FW-1:OFF_W];
						free_off_q  <= free_pos[OFF_W-1:0];
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						id_out_q <= '0;
						status_q <= bia_pkg::ST_RANGE;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					id_out_q <= '0;
					status_q <= bia_pkg::ST_OK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`BIA_ASSERT(a_done_not_busy, done |-> !busy, "result beat while still busy")
	`BIA_ASSERT_NEXT(a_accept_runs, start && !busy, busy || done, "accepted item left no trace")
	`BIA_ASSERT(a_full_id, (done && status == bia_pkg::ST_FULL) |-> (id_out == bia_pkg::ALLOC_FAIL_ID), "full without fail ID")
	`BIA_ASSERT(a_range_free, (done && status == bia_pkg::ST_RANGE) |-> (op_q == bia_pkg::OP_FREE), "range status on non-free item")

endmodule

`default_nettype wire

// ===== rtl/core/bia_word_search.sv =====
`default_nettype none

// Finds the lowest free bit of one map word inside the window [lo, hi).
module bia_word_search (
	input  wire bia_pkg::word_t              data,
	input  wire logic [bia_pkg::OFF_W:0]     lo,
	input  wire logic [bia_pkg::OFF_W:0]     hi,
	output logic                             found,
	output logic [bia_pkg::OFF_W-1:0]        off
);

	bia_pkg::word_t avail;

	// free bits inside the window
	assign avail = ~data & bia_pkg::lomask(hi) & ~bia_pkg::lomask(lo);
	assign found = |avail;

	// priority encode, lowest bit wins
	always_comb begin
		off = '0;
		for (int i = bia_pkg::WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				off = bia_pkg::OFF_W'(i);
			end
		end
	end

endmodule

`default_nettype wire
